### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/imbt_pkg.sv
// shared constants, types and codes for the breakpoint table
package imbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 16;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [STATUS_W-1:0]   status_t;

  // item functions
  localparam logic FN_ASSIGN = 1'b0;
  localparam logic FN_LOOKUP = 1'b1;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // write port of the table, commit swaps the banks
  typedef struct packed {
    logic   en;
    idx_t   addr;
    key_t   key;
    value_t val;
    logic   commit;
  } tbl_wr_t;

  // key compare result against the chosen operand
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    cnt_t count;
  } seq_stat_t;

endpackage

### hdl/imbt_keycmp.sv
// shared key comparator used by every scan step
module imbt_keycmp (
  input  imbt_pkg::key_t     key,
  input  imbt_pkg::key_t     operand,
  output imbt_pkg::cmp_res_t res
);
  import imbt_pkg::*;

  // table key against lookup key, range begin or range end
  always_comb begin
    res.lt = key < operand;
    res.eq = key == operand;
  end

endmodule

### hdl/imbt_table.sv
// two-bank breakpoint register file: one bank live, the other rebuilt on assign
module imbt_table (
  input  logic              clk,
  input  logic              rst_n,
  input  imbt_pkg::idx_t    rd_addr,
  output imbt_pkg::key_t    rd_key,
  output imbt_pkg::value_t  rd_val,
  input  imbt_pkg::tbl_wr_t wr
);
  import imbt_pkg::*;

  key_t   key_mem [2][TABLE_DEPTH];
  value_t val_mem [2][TABLE_DEPTH];
  logic   bank_r;
  logic   bank_nxt;

  // live bank swaps when a rebuilt table is committed
  always_comb begin
    bank_nxt = bank_r;
    if (wr.commit) begin
      bank_nxt = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  // writes always go to the shadow bank
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[~bank_r][wr.addr] <= wr.key;
      val_mem[~bank_r][wr.addr] <= wr.val;
    end
  end

  // single read port on the live bank
  assign rd_key = key_mem[bank_r][rd_addr];
  assign rd_val = val_mem[bank_r][rd_addr];

endmodule

### hdl/imbt_seq.sv
// sequencer: scans, checks room and rebuilds the table one entry a cycle
module imbt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_func,
  input  imbt_pkg::key_t      in_key_begin,
  input  imbt_pkg::key_t      in_key_end,
  input  imbt_pkg::value_t    in_new_value,
  input  imbt_pkg::value_t    default_value,
  input  imbt_pkg::key_t      rd_key,
  input  imbt_pkg::value_t    rd_val,
  input  imbt_pkg::cmp_res_t  cmp,
  output imbt_pkg::idx_t      rd_addr,
  output imbt_pkg::key_t      cmp_op,
  output imbt_pkg::tbl_wr_t   tbl_wr,
  output imbt_pkg::seq_stat_t stat,
  output logic                out_valid,
  output imbt_pkg::value_t    out_found_value,
  output imbt_pkg::status_t   out_status
);
  import imbt_pkg::*;

  localparam int NEED_W = CNT_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOOK    = 4'd1;
  localparam logic [3:0] S_SCAN_LO = 4'd2;
  localparam logic [3:0] S_SCAN_HI = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_COPY_LO = 4'd5;
  localparam logic [3:0] S_INS_B   = 4'd6;
  localparam logic [3:0] S_INS_E   = 4'd7;
  localparam logic [3:0] S_COPY_HI = 4'd8;

  logic [3:0]        state_r, state_nxt;
  cnt_t              count_r, count_nxt;
  cnt_t              idx_r, idx_nxt;
  cnt_t              n_r, n_nxt;
  cnt_t              lo_r, lo_nxt;
  cnt_t              er_r, er_nxt;
  logic              ep_r, ep_nxt;
  key_t              kb_r, kb_nxt;
  key_t              ke_r, ke_nxt;
  value_t            val_r, val_nxt;
  value_t            acc_r, acc_nxt;
  logic              ov_r, ov_nxt;
  value_t            ofv_r, ofv_nxt;
  status_t           ost_r, ost_nxt;
  logic [NEED_W-1:0] need;
  logic              at_end;
  logic              full;

  // entries needed after the assign
  always_comb begin
    need = {1'b0, count_r} - {1'b0, er_r} + NEED_W'(1) + NEED_W'(!ep_r);
    full = need > NEED_W'(TABLE_DEPTH);
  end

  assign at_end  = idx_r == count_r;
  assign rd_addr = idx_r[IDX_W-1:0];
  assign cmp_op  = (state_r == S_SCAN_HI) ? ke_r : kb_r;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    er_nxt    = er_r;
    ep_nxt    = ep_r;
    kb_nxt    = kb_r;
    ke_nxt    = ke_r;
    val_nxt   = val_r;
    acc_nxt   = acc_r;
    ov_nxt    = 1'b0;
    ofv_nxt   = ofv_r;
    ost_nxt   = ost_r;
    tbl_wr    = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          kb_nxt  = in_key_begin;
          ke_nxt  = in_key_end;
          val_nxt = in_new_value;
          acc_nxt = default_value;
          idx_nxt = '0;
          ep_nxt  = 1'b0;
          if (in_func == FN_LOOKUP) begin
            state_nxt = S_LOOK;
          end else if (in_key_begin >= in_key_end) begin
            ov_nxt  = 1'b1;
            ofv_nxt = '0;
            ost_nxt = ST_EMPTY;
          end else begin
            state_nxt = S_SCAN_LO;
          end
        end
      end
      // walk while the breakpoint key is at or below the lookup key
      S_LOOK: begin
        if (at_end || !(cmp.lt || cmp.eq)) begin
          ov_nxt    = 1'b1;
          ofv_nxt   = acc_r;
          ost_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          acc_nxt = rd_val;
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      // entries below the range begin are kept in place
      S_SCAN_LO: begin
        if (at_end) begin
          lo_nxt    = idx_r;
          er_nxt    = '0;
          state_nxt = S_CHECK;
        end else if (cmp.lt) begin
          acc_nxt = rd_val;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          lo_nxt    = idx_r;
          state_nxt = S_SCAN_HI;
        end
      end
      // entries inside the range are erased, track value in effect at the end
      S_SCAN_HI: begin
        if (at_end || !(cmp.lt || cmp.eq)) begin
          er_nxt    = idx_r - lo_r;
          state_nxt = S_CHECK;
        end else if (cmp.lt) begin
          acc_nxt = rd_val;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          ep_nxt    = 1'b1;
          acc_nxt   = rd_val;
          er_nxt    = idx_r - lo_r;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (full) begin
          ov_nxt    = 1'b1;
          ofv_nxt   = '0;
          ost_nxt   = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = '0;
          n_nxt     = '0;
          state_nxt = S_COPY_LO;
        end
      end
      // copy the kept prefix into the shadow bank
      S_COPY_LO: begin
        if (idx_r == lo_r) begin
          state_nxt = S_INS_B;
        end else begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = n_r[IDX_W-1:0];
          tbl_wr.key  = rd_key;
          tbl_wr.val  = rd_val;
          idx_nxt     = idx_r + CNT_W'(1);
          n_nxt       = n_r + CNT_W'(1);
        end
      end
      S_INS_B: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = n_r[IDX_W-1:0];
        tbl_wr.key  = kb_r;
        tbl_wr.val  = val_r;
        n_nxt       = n_r + CNT_W'(1);
        if (ep_r) begin
          idx_nxt   = lo_r + er_r;
          state_nxt = S_COPY_HI;
        end else begin
          state_nxt = S_INS_E;
        end
      end
      // restore the old value at the range end
      S_INS_E: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = n_r[IDX_W-1:0];
        tbl_wr.key  = ke_r;
        tbl_wr.val  = acc_r;
        n_nxt       = n_r + CNT_W'(1);
        idx_nxt     = lo_r + er_r;
        state_nxt   = S_COPY_HI;
      end
      // copy the tail, then swap banks
      S_COPY_HI: begin
        if (at_end) begin
          tbl_wr.commit = 1'b1;
          count_nxt     = n_r;
          ov_nxt        = 1'b1;
          ofv_nxt       = '0;
          ost_nxt       = ST_OK;
          state_nxt     = S_IDLE;
        end else begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = n_r[IDX_W-1:0];
          tbl_wr.key  = rd_key;
          tbl_wr.val  = rd_val;
          idx_nxt     = idx_r + CNT_W'(1);
          n_nxt       = n_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    lo_r  <= lo_nxt;
    er_r  <= er_nxt;
    ep_r  <= ep_nxt;
    kb_r  <= kb_nxt;
    ke_r  <= ke_nxt;
    val_r <= val_nxt;
    acc_r <= acc_nxt;
    ofv_r <= ofv_nxt;
    ost_r <= ost_nxt;
  end

  assign stat.busy       = state_r != S_IDLE;
  assign stat.count      = count_r;
  assign out_valid       = ov_r;
  assign out_found_value = ofv_r;
  assign out_status      = ost_r;

endmodule

### hdl/interval_map_breakpoint_table_core.sv
// top level of the interval map breakpoint table
// lookup: walks the breakpoints at or below the key, then strobes the result
// assign: an empty range is rejected with status empty; otherwise the scan and the rebuild
// run one entry a cycle through the single table read port
// one item at a time, busy high meanwhile; synchronous active-low reset empties the table
`include "assert_macros.svh"

module interval_map_breakpoint_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  imbt_pkg::key_t      in_key_begin,
  input  imbt_pkg::key_t      in_key_end,
  input  imbt_pkg::value_t    in_new_value,
  output logic                out_valid,
  output imbt_pkg::value_t    out_found_value,
  output imbt_pkg::status_t   out_status,
  input  logic                cfg_we,
  input  imbt_pkg::value_t    cfg_wdata
);
  import imbt_pkg::*;

  value_t    default_r, default_nxt;
  key_t      rd_key;
  value_t    rd_val;
  idx_t      rd_addr;
  key_t      cmp_op;
  cmp_res_t  cmp;
  tbl_wr_t   tbl_wr;
  seq_stat_t stat;
  logic      accept;

  // default value register
  always_comb begin
    default_nxt = default_r;
    if (cfg_we) begin
      default_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
    end else begin
      default_r <= default_nxt;
    end
  end

  imbt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val),
    .wr      (tbl_wr)
  );

  imbt_keycmp u_cmp (
    .key     (rd_key),
    .operand (cmp_op),
    .res     (cmp)
  );

  imbt_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_func         (in_func),
    .in_key_begin    (in_key_begin),
    .in_key_end      (in_key_end),
    .in_new_value    (in_new_value),
    .default_value   (default_r),
    .rd_key          (rd_key),
    .rd_val          (rd_val),
    .cmp             (cmp),
    .rd_addr         (rd_addr),
    .cmp_op          (cmp_op),
    .tbl_wr          (tbl_wr),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_found_value (out_found_value),
    .out_status      (out_status)
  );

  assign busy   = stat.busy;
  assign accept = start && !stat.busy;

  // checks
  `ASSERT_CLK(a_accept_progress, accept |=> (stat.busy || out_valid), "beat accepted but no work started")
  `ASSERT_CLK(a_non_ok_zero, (out_valid && (out_status != ST_OK)) |-> (out_found_value == '0), "found value not zero on rejected assign")
  `ASSERT_CLK(a_count_change, !$stable(stat.count) |-> (out_valid && (out_status == ST_OK)), "entry count moved without a completed assign")
  `ASSERT_CLK(a_count_bound, stat.count <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")

endmodule
